### hdl/itpc_pkg.sv
`default_nettype none
package itpc_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);

   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_LOWER_A = "a";
   localparam logic [7:0] CHAR_LOWER_Z = "z";
   localparam logic [7:0] CHAR_DIGIT_0 = "0";
   localparam logic [7:0] CHAR_DIGIT_9 = "9";
   localparam logic [7:0] CHAR_OPEN    = "(";
   localparam logic [7:0] CHAR_CLOSE   = ")";
   localparam logic [7:0] CHAR_POW     = "^";
   localparam logic [7:0] CHAR_MUL     = "*";
   localparam logic [7:0] CHAR_DIV     = "/";
   localparam logic [7:0] CHAR_ADD     = "+";
   localparam logic [7:0] CHAR_SUB     = "-";

   typedef enum logic [2:0] {
      CODE_NONE = 3'd0,
      CODE_OPEN = 3'd1,
      CODE_POW  = 3'd2,
      CODE_MUL  = 3'd3,
      CODE_DIV  = 3'd4,
      CODE_ADD  = 3'd5,
      CODE_SUB  = 3'd6
   } code_type;

   typedef enum logic [2:0] {
      PREV_NONE,
      PREV_LETTER,
      PREV_DIGIT,
      PREV_CLOSE,
      PREV_OPEN,
      PREV_OPER
   } prev_type;

   typedef enum logic [1:0] {
      ERR_NONE,
      ERR_ADJACENT,
      ERR_ILLEGAL,
      ERR_OVERFLOW
   } err_type;

   typedef enum logic [1:0] {
      EMIT_TOP,
      EMIT_SYM,
      EMIT_STATUS
   } emit_type;

   typedef enum logic [1:0] {
      LOAD_MUL,
      LOAD_OPEN,
      LOAD_OPER
   } load_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_PUSH_MUL_SYM,
      S_PUSH_MUL_OPEN,
      S_PUSH_OPEN,
      S_PUSH_OPER,
      S_SYM,
      S_CLOSE,
      S_FLUSH,
      S_ERROR
   } state_type;

   typedef struct packed {
      logic [7:0] symbol;
      logic       end_of_expression;
   } req_type;

   typedef struct packed {
      logic [7:0] out_symbol;
      logic       out_valid;
      logic       out_last;
      logic [1:0] error_code;
   } rsp_type;

   typedef struct packed {
      logic     accept;
      logic     load;
      load_type load_sel;
      logic     push;
      logic     pop;
      logic     emit;
      emit_type emit_sel;
      logic     out_last;
      err_type  err;
      logic     set_prev;
      prev_type prev;
      logic     clear;
      logic     set_discard;
   } cmd_type;

   typedef struct packed {
      logic is_letter;
      logic is_digit;
      logic is_open;
      logic is_close;
      logic is_oper;
      logic discarding;
      logic end_flag;
      logic prev_mul_operand;
      logic prev_mul_open;
      logic prev_oper;
      logic open_zero;
      logic stack_empty;
      logic stack_full;
      logic top_open;
      logic pop_hit;
      logic ops_zero;
      logic ops_one;
      logic emitted_any;
      logic out_free;
   } status_type;

   function automatic logic [7:0] code_char(input code_type code);
      logic [7:0] ch;
      unique case (code)
         CODE_OPEN: ch = CHAR_OPEN;
         CODE_POW:  ch = CHAR_POW;
         CODE_MUL:  ch = CHAR_MUL;
         CODE_DIV:  ch = CHAR_DIV;
         CODE_ADD:  ch = CHAR_ADD;
         CODE_SUB:  ch = CHAR_SUB;
         default:   ch = CHAR_NUL;
      endcase
      return ch;
   endfunction

   function automatic logic [2:0] code_prio(input code_type code);
      logic [2:0] prio;
      unique case (code) inside
         CODE_OPEN:          prio = 3'd1;
         CODE_POW:           prio = 3'd4;
         CODE_MUL, CODE_DIV: prio = 3'd3;
         CODE_ADD, CODE_SUB: prio = 3'd2;
         default:            prio = 3'd0;
      endcase
      return prio;
   endfunction

   function automatic code_type char_code(input logic [7:0] ch);
      code_type code;
      unique case (ch)
         CHAR_POW: code = CODE_POW;
         CHAR_MUL: code = CODE_MUL;
         CHAR_DIV: code = CODE_DIV;
         CHAR_ADD: code = CODE_ADD;
         CHAR_SUB: code = CODE_SUB;
         default:  code = CODE_NONE;
      endcase
      return code;
   endfunction

endpackage
`default_nettype wire

### hdl/itpc_datapath.sv
`default_nettype none
module itpc_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire itpc_pkg::req_type    req_data,
   input  wire logic                 rsp_stall,
   output logic                      rsp_valid,
   output itpc_pkg::rsp_type         rsp_data,
   input  wire itpc_pkg::cmd_type    cmd,
   output itpc_pkg::status_type      status
);

   logic [7:0]                   sym_ff;
   logic                         end_ff;
   logic [itpc_pkg::CNT_W-1:0]   sc_ff, sc_in;
   logic [itpc_pkg::CNT_W-1:0]   oc_ff, oc_in;
   logic [itpc_pkg::CNT_W-1:0]   rd_idx;
   itpc_pkg::prev_type           prev_ff, prev_in;
   logic                         disc_ff, disc_in;
   logic                         emitted_ff, emitted_in;
   itpc_pkg::code_type           code_ff, code_in;
   itpc_pkg::code_type           top_ff;
   itpc_pkg::code_type           op_code;
   logic                         rsp_valid_ff, rsp_valid_in;
   itpc_pkg::rsp_type            rsp_data_ff, rsp_data_in;
   itpc_pkg::rsp_type            emit_data;
   itpc_pkg::code_type           mem [itpc_pkg::STACK_DEPTH];

   assign op_code   = itpc_pkg::char_code(sym_ff);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      status.is_letter        = (sym_ff >= itpc_pkg::CHAR_LOWER_A) &&
                                (sym_ff <= itpc_pkg::CHAR_LOWER_Z);
      status.is_digit         = (sym_ff >= itpc_pkg::CHAR_DIGIT_0) &&
                                (sym_ff <= itpc_pkg::CHAR_DIGIT_9);
      status.is_open          = sym_ff == itpc_pkg::CHAR_OPEN;
      status.is_close         = sym_ff == itpc_pkg::CHAR_CLOSE;
      status.is_oper          = op_code != itpc_pkg::CODE_NONE;
      status.discarding       = disc_ff;
      status.end_flag         = end_ff;
      status.prev_mul_operand = (prev_ff == itpc_pkg::PREV_LETTER) ||
                                (prev_ff == itpc_pkg::PREV_DIGIT) ||
                                (prev_ff == itpc_pkg::PREV_CLOSE);
      status.prev_mul_open    = (prev_ff == itpc_pkg::PREV_LETTER) ||
                                (prev_ff == itpc_pkg::PREV_CLOSE);
      status.prev_oper        = prev_ff == itpc_pkg::PREV_OPER;
      status.open_zero        = oc_ff == '0;
      status.stack_empty      = sc_ff == '0;
      status.stack_full       = sc_ff == itpc_pkg::CNT_W'(itpc_pkg::STACK_DEPTH);
      status.top_open         = top_ff == itpc_pkg::CODE_OPEN;
      status.pop_hit          = (code_ff != itpc_pkg::CODE_OPEN) &&
                                (itpc_pkg::code_prio(top_ff) >= itpc_pkg::code_prio(code_ff));
      status.ops_zero         = sc_ff == oc_ff;
      status.ops_one          = sc_ff == (oc_ff + itpc_pkg::CNT_W'(1));
      status.emitted_any      = emitted_ff;
      status.out_free         = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      sc_in      = sc_ff;
      oc_in      = oc_ff;
      prev_in    = prev_ff;
      disc_in    = disc_ff;
      code_in    = code_ff;
      emitted_in = emitted_ff;
      if (cmd.load) begin
         unique case (cmd.load_sel)
            itpc_pkg::LOAD_MUL:  code_in = itpc_pkg::CODE_MUL;
            itpc_pkg::LOAD_OPEN: code_in = itpc_pkg::CODE_OPEN;
            itpc_pkg::LOAD_OPER: code_in = op_code;
            default:             code_in = code_ff;
         endcase
      end
      if (cmd.push) begin
         sc_in = sc_ff + itpc_pkg::CNT_W'(1);
         if (code_ff == itpc_pkg::CODE_OPEN) begin
            oc_in = oc_ff + itpc_pkg::CNT_W'(1);
         end
      end
      if (cmd.pop) begin
         sc_in = sc_ff - itpc_pkg::CNT_W'(1);
         if (top_ff == itpc_pkg::CODE_OPEN) begin
            oc_in = oc_ff - itpc_pkg::CNT_W'(1);
         end
      end
      if (cmd.set_prev) begin
         prev_in = cmd.prev;
      end
      if (cmd.accept) begin
         emitted_in = 1'b0;
      end
      if (cmd.emit) begin
         emitted_in = 1'b1;
      end
      if (cmd.clear) begin
         sc_in   = '0;
         oc_in   = '0;
         prev_in = itpc_pkg::PREV_NONE;
         disc_in = cmd.set_discard;
      end
      rd_idx = sc_in - itpc_pkg::CNT_W'(1);
   end

   always_comb begin
      emit_data.out_symbol = itpc_pkg::CHAR_NUL;
      emit_data.out_valid  = 1'b0;
      emit_data.out_last   = 1'b1;
      emit_data.error_code = cmd.err;
      unique case (cmd.emit_sel)
         itpc_pkg::EMIT_TOP: begin
            emit_data.out_symbol = itpc_pkg::code_char(top_ff);
            emit_data.out_valid  = 1'b1;
            emit_data.out_last   = cmd.out_last;
            emit_data.error_code = itpc_pkg::ERR_NONE;
         end
         itpc_pkg::EMIT_SYM: begin
            emit_data.out_symbol = sym_ff;
            emit_data.out_valid  = 1'b1;
            emit_data.out_last   = cmd.out_last;
            emit_data.error_code = itpc_pkg::ERR_NONE;
         end
         default: begin
            emit_data.out_symbol = itpc_pkg::CHAR_NUL;
         end
      endcase
      rsp_valid_in = cmd.emit ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_data_in  = cmd.emit ? emit_data : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_ff        <= '0;
         oc_ff        <= '0;
         prev_ff      <= itpc_pkg::PREV_NONE;
         disc_ff      <= 1'b0;
         emitted_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sc_ff        <= sc_in;
         oc_ff        <= oc_in;
         prev_ff      <= prev_in;
         disc_ff      <= disc_in;
         emitted_ff   <= emitted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sym_ff <= req_data.symbol;
         end_ff <= req_data.end_of_expression;
      end
      code_ff     <= code_in;
      rsp_data_ff <= rsp_data_in;
      if (cmd.push) begin
         mem[sc_ff[itpc_pkg::ADDR_W-1:0]] <= code_ff;
      end
      top_ff <= cmd.push ? code_ff : mem[rd_idx[itpc_pkg::ADDR_W-1:0]];
   end

endmodule
`default_nettype wire

### hdl/itpc_ctrl.sv
`default_nettype none
module itpc_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire itpc_pkg::status_type status,
   output itpc_pkg::cmd_type         cmd
);

   itpc_pkg::state_type state_ff, state_in;
   itpc_pkg::err_type   err_ff, err_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= itpc_pkg::S_IDLE;
         err_ff   <= itpc_pkg::ERR_NONE;
      end else begin
         state_ff <= state_in;
         err_ff   <= err_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      err_in    = err_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff) inside
         itpc_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = itpc_pkg::S_DISPATCH;
            end
         end

         itpc_pkg::S_DISPATCH: begin
            if (status.discarding) begin
               if (status.end_flag) begin
                  cmd.clear = 1'b1;
               end
               state_in = itpc_pkg::S_IDLE;
            end else if (status.is_letter || status.is_digit) begin
               if (status.prev_mul_operand) begin
                  cmd.load     = 1'b1;
                  cmd.load_sel = itpc_pkg::LOAD_MUL;
                  state_in     = itpc_pkg::S_PUSH_MUL_SYM;
               end else begin
                  state_in = itpc_pkg::S_SYM;
               end
            end else if (status.is_open) begin
               cmd.set_prev = 1'b1;
               cmd.prev     = itpc_pkg::PREV_OPEN;
               cmd.load     = 1'b1;
               if (status.prev_mul_open) begin
                  cmd.load_sel = itpc_pkg::LOAD_MUL;
                  state_in     = itpc_pkg::S_PUSH_MUL_OPEN;
               end else begin
                  cmd.load_sel = itpc_pkg::LOAD_OPEN;
                  state_in     = itpc_pkg::S_PUSH_OPEN;
               end
            end else if (status.is_close) begin
               cmd.set_prev = 1'b1;
               cmd.prev     = itpc_pkg::PREV_CLOSE;
               if (!status.open_zero) begin
                  state_in = itpc_pkg::S_CLOSE;
               end else begin
                  state_in = status.end_flag ? itpc_pkg::S_FLUSH : itpc_pkg::S_IDLE;
               end
            end else if (status.is_oper) begin
               if (status.prev_oper) begin
                  err_in   = itpc_pkg::ERR_ADJACENT;
                  state_in = itpc_pkg::S_ERROR;
               end else begin
                  cmd.set_prev = 1'b1;
                  cmd.prev     = itpc_pkg::PREV_OPER;
                  cmd.load     = 1'b1;
                  cmd.load_sel = itpc_pkg::LOAD_OPER;
                  state_in     = itpc_pkg::S_PUSH_OPER;
               end
            end else begin
               err_in   = itpc_pkg::ERR_ILLEGAL;
               state_in = itpc_pkg::S_ERROR;
            end
         end

         itpc_pkg::S_PUSH_MUL_SYM, itpc_pkg::S_PUSH_MUL_OPEN,
         itpc_pkg::S_PUSH_OPEN, itpc_pkg::S_PUSH_OPER: begin
            if (!status.stack_empty && status.pop_hit) begin
               if (status.out_free) begin
                  cmd.pop      = 1'b1;
                  cmd.emit     = 1'b1;
                  cmd.emit_sel = itpc_pkg::EMIT_TOP;
               end
            end else if (status.stack_full) begin
               err_in   = itpc_pkg::ERR_OVERFLOW;
               state_in = itpc_pkg::S_ERROR;
            end else begin
               cmd.push = 1'b1;
               if (state_ff == itpc_pkg::S_PUSH_MUL_SYM) begin
                  state_in = itpc_pkg::S_SYM;
               end else if (state_ff == itpc_pkg::S_PUSH_MUL_OPEN) begin
                  cmd.load     = 1'b1;
                  cmd.load_sel = itpc_pkg::LOAD_OPEN;
                  state_in     = itpc_pkg::S_PUSH_OPEN;
               end else begin
                  state_in = status.end_flag ? itpc_pkg::S_FLUSH : itpc_pkg::S_IDLE;
               end
            end
         end

         itpc_pkg::S_SYM: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = itpc_pkg::EMIT_SYM;
               cmd.out_last = status.end_flag && status.ops_zero;
               cmd.set_prev = 1'b1;
               cmd.prev     = status.is_letter ? itpc_pkg::PREV_LETTER : itpc_pkg::PREV_DIGIT;
               state_in     = status.end_flag ? itpc_pkg::S_FLUSH : itpc_pkg::S_IDLE;
            end
         end

         itpc_pkg::S_CLOSE: begin
            if (status.top_open) begin
               cmd.pop  = 1'b1;
               state_in = status.end_flag ? itpc_pkg::S_FLUSH : itpc_pkg::S_IDLE;
            end else if (status.out_free) begin
               cmd.pop      = 1'b1;
               cmd.emit     = 1'b1;
               cmd.emit_sel = itpc_pkg::EMIT_TOP;
               cmd.out_last = status.end_flag && status.ops_one;
            end
         end

         itpc_pkg::S_FLUSH: begin
            if (status.stack_empty) begin
               if (status.emitted_any) begin
                  cmd.clear = 1'b1;
                  state_in  = itpc_pkg::S_IDLE;
               end else if (status.out_free) begin
                  cmd.emit     = 1'b1;
                  cmd.emit_sel = itpc_pkg::EMIT_STATUS;
                  cmd.err      = itpc_pkg::ERR_NONE;
                  cmd.clear    = 1'b1;
                  state_in     = itpc_pkg::S_IDLE;
               end
            end else if (status.top_open) begin
               cmd.pop = 1'b1;
            end else if (status.out_free) begin
               cmd.pop      = 1'b1;
               cmd.emit     = 1'b1;
               cmd.emit_sel = itpc_pkg::EMIT_TOP;
               cmd.out_last = status.ops_one;
            end
         end

         itpc_pkg::S_ERROR: begin
            if (status.out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_sel    = itpc_pkg::EMIT_STATUS;
               cmd.err         = err_ff;
               cmd.clear       = 1'b1;
               cmd.set_discard = !status.end_flag;
               state_in        = itpc_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = itpc_pkg::S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

### hdl/infix_to_postfix_converter.sv
`default_nettype none
// Channel   Ports                              Beat
// req       req_valid, req_stall, req_data     one infix character and its end flag
// rsp       rsp_valid, rsp_stall, rsp_data     one postfix character or a status result
//
// One character per visit to idle: idle accepts it, dispatch decodes it, then each stack
// pop, push or result is a step of its own; an operator first pops entries of equal or higher
// priority and is then pushed. At the end flag every stacked operator is popped and emitted.
// Each stack pop reads the next top from the stack memory's single read port in that cycle.
// Reset clears the counts and flags; the stack memory is not cleared.
// A held rsp_stall with rsp_valid high freezes the controller in any state that produces a result.
module infix_to_postfix_converter (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire itpc_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output itpc_pkg::rsp_type      rsp_data
);

   itpc_pkg::cmd_type    cmd;
   itpc_pkg::status_type status;

   itpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   itpc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
`default_nettype wire
